[rtl/abr_pkg.sv]
// Package for the alternate block reverse unit: field widths, register
// indexes and the control struct passed from the sequencer to the output stage.
// No dependencies.
package abr_pkg;

    localparam int VALUE_W    = 32;
    localparam int GSIZE_W    = 7;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_COUNT = 2'd1;

    typedef struct packed {
        logic load;
        logic from_ram;
        logic run_end;
    } t_out_ctl;

endpackage

[rtl/abr_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module abr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/abr_ctrl.sv]
// Sequencer of the alternate block reverse unit: configuration registers,
// stream and group counters, buffer writes and the reverse read-out of a group.
// Depends on abr_pkg.
module abr_ctrl import abr_pkg::*; #(
    parameter int MAX_GROUP = 64,
    localparam int AW = $clog2(MAX_GROUP)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_out_free,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_ctl              o_out_ctl,
    output logic                  o_we,
    output logic [AW-1:0]         o_waddr,
    output logic [AW-1:0]         o_raddr
);

    typedef enum logic {S_IN, S_DRAIN} t_state;

    t_state               r_state, n_state;
    logic [GSIZE_W-1:0]   r_b, n_b;
    logic [COUNT_W-1:0]   r_n, n_n;
    logic [COUNT_W-1:0]   r_idx, n_idx;
    logic [GSIZE_W-1:0]   r_fill, n_fill;
    logic                 r_odd, n_odd;
    logic [AW-1:0]        r_k, n_k;
    logic                 r_pend, n_pend;

    logic                 in_acc;
    logic                 cfg_wr;
    logic                 cfg_pass;
    logic                 buf_mode;
    logic [COUNT_W-1:0]   start;
    logic                 complete;
    logic [GSIZE_W-1:0]   fill_inc;
    logic                 group_done;
    logic [COUNT_W-1:0]   idx_inc;
    logic                 wrap;

    assign cfg_pass = (r_b < GSIZE_W'(2)) || ({1'b0, r_b} > 8'(MAX_GROUP))
                      || ({9'd0, r_b} > r_n);
    assign start      = r_idx - {9'd0, r_fill};
    assign complete   = ({1'b0, start} + {10'd0, r_b}) <= {1'b0, r_n};
    assign buf_mode   = !cfg_pass && !r_odd && complete;
    assign fill_inc   = r_fill + GSIZE_W'(1);
    assign group_done = fill_inc >= r_b;
    assign idx_inc    = r_idx + COUNT_W'(1);
    assign wrap       = idx_inc >= r_n;

    assign o_in_stall  = (r_state == S_DRAIN) || (!buf_mode && !i_out_free);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = (r_state == S_IN) && !i_in_valid;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_waddr     = r_fill[AW-1:0];
    assign o_raddr     = n_k;

    always_comb begin
        n_state   = r_state;
        n_b       = r_b;
        n_n       = r_n;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_odd     = r_odd;
        n_k       = r_k;
        n_pend    = r_pend;
        o_out_ctl = '0;
        o_we      = 1'b0;
        unique case (r_state)
            S_IN: begin
                if (in_acc) begin
                    if (cfg_pass) begin
                        o_out_ctl.load    = 1'b1;
                        o_out_ctl.run_end = 1'b1;
                        n_fill            = '0;
                        n_odd             = 1'b0;
                    end else if (buf_mode) begin
                        o_we = 1'b1;
                        if (group_done) begin
                            n_state = S_DRAIN;
                            n_k     = AW'(r_b - GSIZE_W'(1));
                            n_pend  = 1'b0;
                            n_fill  = '0;
                            n_odd   = 1'b1;
                        end else begin
                            n_fill = fill_inc;
                        end
                    end else begin
                        o_out_ctl.load    = 1'b1;
                        o_out_ctl.run_end = 1'b1;
                        if (group_done) begin
                            n_fill = '0;
                            n_odd  = !r_odd;
                        end else begin
                            n_fill = fill_inc;
                        end
                    end
                    n_idx = idx_inc;
                    if (wrap) begin
                        n_idx  = '0;
                        n_fill = '0;
                        n_odd  = 1'b0;
                    end
                end else if (cfg_wr) begin
                    unique case (i_cfg_index)
                        REG_GROUP_SIZE: begin
                            n_b    = i_cfg_data[GSIZE_W-1:0];
                            n_idx  = '0;
                            n_fill = '0;
                            n_odd  = 1'b0;
                        end
                        REG_TOTAL_COUNT: begin
                            n_n    = i_cfg_data[COUNT_W-1:0];
                            n_idx  = '0;
                            n_fill = '0;
                            n_odd  = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                n_pend = 1'b1;
                if (r_pend && i_out_free) begin
                    o_out_ctl.load     = 1'b1;
                    o_out_ctl.from_ram = 1'b1;
                    o_out_ctl.run_end  = (r_k == '0);
                    if (r_k == '0) begin
                        n_state = S_IN;
                    end else begin
                        n_k = r_k - AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_b     <= '0;
            r_n     <= '0;
            r_idx   <= '0;
            r_fill  <= '0;
            r_odd   <= 1'b0;
            r_k     <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_b     <= n_b;
            r_n     <= n_n;
            r_idx   <= n_idx;
            r_fill  <= n_fill;
            r_odd   <= n_odd;
            r_k     <= n_k;
            r_pend  <= n_pend;
        end
    end

    // A group read-out starts at its last entry with no read data yet valid.
    a_drain_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IN && n_state == S_DRAIN) |=>
            (r_k == AW'(r_b - GSIZE_W'(1))) && !r_pend)
        else $error("group read-out did not start at the last entry");

    // The read-out ends only after the first entry of the group is delivered.
    a_drain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && n_state == S_IN) |-> (o_out_ctl.load && r_k == '0))
        else $error("group read-out ended early");

    // In grouping mode the fill count stays below the group size.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_pass |-> (r_fill < r_b))
        else $error("group fill count out of range");

    // A pass-through item leaves no partial group behind.
    a_pass_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && cfg_pass) |=> (r_fill == '0) && !r_odd)
        else $error("pass-through item left group state");

endmodule

[rtl/alternate_block_reverse.sv]
// Alternate block reverse unit. Items of a stream are counted in groups of
// group_size; every complete even-numbered group is held in a buffer RAM and
// sent out in reverse order once its last item arrives. Odd groups, a trailing
// partial group and all items when the group size is below 2, above MAX_GROUP
// or above total_count pass straight through with run_end set.
// Input channel: i_in_valid, o_in_stall, i_value. Output channel: o_out_valid,
// i_out_stall, o_value_out, o_run_end. An item moves when valid is high and
// stall is low. Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and
// i_cfg_data; index 0 is group_size, index 1 is total_count, and a write
// restarts the stream and drops any buffered items.
// A pass-through item appears at the output in the cycle after it is accepted;
// one item per cycle is sustained while the receiver does not stall. A
// buffered group is stored as it arrives, then read back from the buffer RAM
// last entry first, one entry per cycle while the receiver does not stall;
// input is stalled during the read-back. When the receiver stalls, the output
// register holds its item and the input is stalled for any pass-through item.
// Synchronous active-low reset clears the counters and both registers to 0.
// Depends on abr_pkg, abr_ctrl and abr_ram.
module alternate_block_reverse import abr_pkg::*; #(
    parameter int MAX_GROUP = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [VALUE_W-1:0]  o_value_out,
    output logic                       o_run_end,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(MAX_GROUP);

    t_out_ctl             out_ctl;
    logic                 out_free;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [VALUE_W-1:0]   rdata;

    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_value_out;
    logic                 r_run_end;

    assign out_free = !r_out_valid || !i_out_stall;

    abr_ctrl #(
        .MAX_GROUP (MAX_GROUP)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_free  (out_free),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_ctl   (out_ctl),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_raddr     (raddr)
    );

    abr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_GROUP)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_ctl.load) begin
            r_value_out <= out_ctl.from_ram ? rdata : i_value;
            r_run_end   <= out_ctl.run_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_value_out;
    assign o_run_end   = r_run_end;

endmodule
